// File: rtl/lftc_pkg.sv
package lftc_pkg;

   localparam int DATA_W     = 16;
   localparam int DIFF_W     = DATA_W + 1;
   localparam int STR_W      = 13;
   localparam int TRANS_W    = 15;
   localparam int TERM_W     = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int SAT_MAX = 32767;
   localparam int SAT_MIN = -32768;

   localparam logic [CSR_IDX_W-1:0] CSR_MONO_MODE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGHLIGHT_ENABLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LUMA_GAIN        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HL_KNEE          = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HL_RAMP          = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DETAIL_STRENGTH  = 3'd5;

   typedef struct packed {
      logic                 mono_mode;
      logic                 highlight_enable;
      logic [STR_W-1:0]     luma_gain;
      logic [DATA_W-1:0]    hl_knee;
      logic [TRANS_W-1:0]   hl_ramp;
      logic [STR_W-1:0]     detail_strength;
   } cfg_type;

   // Rec.709 luma weight of one channel, rounded to the fixed-point grid.
   function automatic int luma_coef(input int lane, input int frac);
      int num;
      begin
         num = (lane == 0) ? 2126 : ((lane == 1) ? 7152 : 722);
         return (num * (1 << frac) + 5000) / 10000;
      end
   endfunction

endpackage

// File: rtl/low_frequency_transfer_compose_core.sv
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | restored, reference, blur_delta, low_rest (r,g,b)
// rsp     | out       | rsp_valid / rsp_ready | out_r, out_g, out_b
// csr     | in        | csr_write_en          | csr_index, csr_write_data
//
// One item per clock sustained through FRACTION_BITS + 6 register stages while rsp_ready is high.
// The depth is set by the restoring divider of the highlight ramp,
// which resolves one quotient bit per stage.
// Synchronous active-high reset clears the stage valid bits and loads register defaults.
// A stall on rsp holds the output register; earlier stages keep filling empty slots,
// so req_ready stays high while any stage holds a bubble.
module low_frequency_transfer_compose_core #(
   parameter int FRACTION_BITS = 12
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [lftc_pkg::DATA_W-1:0]        req_restored_r,
   input  logic signed [lftc_pkg::DATA_W-1:0]        req_restored_g,
   input  logic signed [lftc_pkg::DATA_W-1:0]        req_restored_b,
   input  logic signed [lftc_pkg::DATA_W-1:0]        req_reference_r,
   input  logic signed [lftc_pkg::DATA_W-1:0]        req_reference_g,
   input  logic signed [lftc_pkg::DATA_W-1:0]        req_reference_b,
   input  logic signed [lftc_pkg::DATA_W-1:0]        req_blur_delta_r,
   input  logic signed [lftc_pkg::DATA_W-1:0]        req_blur_delta_g,
   input  logic signed [lftc_pkg::DATA_W-1:0]        req_blur_delta_b,
   input  logic signed [lftc_pkg::DATA_W-1:0]        req_low_rest_r,
   input  logic signed [lftc_pkg::DATA_W-1:0]        req_low_rest_g,
   input  logic signed [lftc_pkg::DATA_W-1:0]        req_low_rest_b,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [lftc_pkg::DATA_W-1:0]        rsp_out_r,
   output logic signed [lftc_pkg::DATA_W-1:0]        rsp_out_g,
   output logic signed [lftc_pkg::DATA_W-1:0]        rsp_out_b,
   input  logic                                      csr_write_en,
   input  logic [lftc_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [lftc_pkg::CSR_DATA_W-1:0]           csr_write_data
);
   import lftc_pkg::*;

   localparam int F      = FRACTION_BITS;
   localparam int N      = F + 6;
   localparam int PROD_W = DATA_W + F + 1;

   cfg_type                  cfg_ff;
   logic [N-1:0]             valid_ff;
   logic [N-1:0]             stage_en;
   logic signed [PROD_W-1:0] prod_r;
   logic signed [PROD_W-1:0] prod_g;
   logic signed [PROD_W-1:0] prod_b;
   logic signed [DIFF_W-1:0] d;
   logic signed [TERM_W-1:0] adj;
   logic signed [TERM_W-1:0] mono_term;
   logic [F:0]               alpha;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mono_mode        <= 1'b0;
         cfg_ff.highlight_enable <= 1'b0;
         cfg_ff.luma_gain        <= STR_W'(4096);
         cfg_ff.hl_knee          <= DATA_W'(3277);
         cfg_ff.hl_ramp          <= TRANS_W'(410);
         cfg_ff.detail_strength  <= STR_W'(0);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MONO_MODE: begin
               cfg_ff.mono_mode <= csr_write_data[0];
            end
            CSR_HIGHLIGHT_ENABLE: begin
               cfg_ff.highlight_enable <= csr_write_data[0];
            end
            CSR_LUMA_GAIN: begin
               cfg_ff.luma_gain <= csr_write_data[STR_W-1:0];
            end
            CSR_HL_KNEE: begin
               cfg_ff.hl_knee <= csr_write_data[DATA_W-1:0];
            end
            CSR_HL_RAMP: begin
               cfg_ff.hl_ramp <= csr_write_data[TRANS_W-1:0];
            end
            CSR_DETAIL_STRENGTH: begin
               cfg_ff.detail_strength <= csr_write_data[STR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A stage loads when it is empty or when the stage after it moves on.
   assign stage_en[N-1] = !valid_ff[N-1] || rsp_ready;
   for (genvar s = 0; s < N - 1; s++) begin : g_en
      assign stage_en[s] = !valid_ff[s] || stage_en[s+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int s = 1; s < N; s++) begin
            if (stage_en[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[N-1];

   lftc_lane #(.FRACTION_BITS(FRACTION_BITS), .LANE(0)) u_lane_r (
      .clock      (clock),
      .stage_en   (stage_en),
      .cfg        (cfg_ff),
      .restored   (req_restored_r),
      .low_rest   (req_low_rest_r),
      .blur_delta (req_blur_delta_r),
      .alpha      (alpha),
      .adj        (adj),
      .mono_term  (mono_term),
      .prod       (prod_r),
      .result     (rsp_out_r)
   );

   lftc_lane #(.FRACTION_BITS(FRACTION_BITS), .LANE(1)) u_lane_g (
      .clock      (clock),
      .stage_en   (stage_en),
      .cfg        (cfg_ff),
      .restored   (req_restored_g),
      .low_rest   (req_low_rest_g),
      .blur_delta (req_blur_delta_g),
      .alpha      (alpha),
      .adj        (adj),
      .mono_term  (mono_term),
      .prod       (prod_g),
      .result     (rsp_out_g)
   );

   lftc_lane #(.FRACTION_BITS(FRACTION_BITS), .LANE(2)) u_lane_b (
      .clock      (clock),
      .stage_en   (stage_en),
      .cfg        (cfg_ff),
      .restored   (req_restored_b),
      .low_rest   (req_low_rest_b),
      .blur_delta (req_blur_delta_b),
      .alpha      (alpha),
      .adj        (adj),
      .mono_term  (mono_term),
      .prod       (prod_b),
      .result     (rsp_out_b)
   );

   lftc_merge #(.FRACTION_BITS(FRACTION_BITS)) u_merge (
      .clock        (clock),
      .stage_en     (stage_en),
      .cfg          (cfg_ff),
      .reference_r  (req_reference_r),
      .reference_g  (req_reference_g),
      .reference_b  (req_reference_b),
      .blur_delta_r (req_blur_delta_r),
      .prod_r       (prod_r),
      .prod_g       (prod_g),
      .prod_b       (prod_b),
      .d            (d),
      .adj          (adj),
      .mono_term    (mono_term)
   );

   lftc_mask #(.FRACTION_BITS(FRACTION_BITS)) u_mask (
      .clock    (clock),
      .stage_en (stage_en),
      .cfg      (cfg_ff),
      .d        (d),
      .alpha    (alpha)
   );

endmodule

// File: rtl/lftc_lane.sv
module lftc_lane #(
   parameter int FRACTION_BITS = 12,
   parameter int LANE          = 0
) (
   input  logic                                         clock,
   input  logic [FRACTION_BITS+5:0]                     stage_en,
   input  lftc_pkg::cfg_type                            cfg,
   input  logic signed [lftc_pkg::DATA_W-1:0]           restored,
   input  logic signed [lftc_pkg::DATA_W-1:0]           low_rest,
   input  logic signed [lftc_pkg::DATA_W-1:0]           blur_delta,
   input  logic [FRACTION_BITS:0]                       alpha,
   input  logic signed [lftc_pkg::TERM_W-1:0]           adj,
   input  logic signed [lftc_pkg::TERM_W-1:0]           mono_term,
   output logic signed [lftc_pkg::DATA_W+FRACTION_BITS:0] prod,
   output logic signed [lftc_pkg::DATA_W-1:0]           result
);
   import lftc_pkg::*;

   localparam int F       = FRACTION_BITS;
   localparam int A_ST    = F + 3;
   localparam int HP_ST   = F + 4;
   localparam int OUT_ST  = F + 5;
   localparam int PROD_W  = DATA_W + F + 1;
   localparam int HPP_W   = DIFF_W + F + 2;
   localparam int SUM_W   = TERM_W + 3;
   localparam int COEF    = luma_coef(LANE, F);
   localparam int HALF    = 1 << (F - 1);
   localparam bit PRIMARY = (LANE == 0);

   logic signed [DATA_W-1:0] rest_ff  [0:HP_ST];
   logic signed [DATA_W-1:0] ldiff_ff [0:HP_ST];
   logic signed [DIFF_W-1:0] hpd_ff   [0:A_ST];
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [DIFF_W-1:0] hpd_in;
   logic signed [HPP_W-1:0]  hpp;
   logic signed [TERM_W-1:0] hp_ff;
   logic signed [TERM_W-1:0] hp_in;
   logic signed [SUM_W-1:0]  term;
   logic signed [SUM_W-1:0]  sum;
   logic signed [DATA_W-1:0] result_ff;
   logic signed [DATA_W-1:0] result_in;

   assign prod_in = PROD_W'(blur_delta) * PROD_W'(COEF);
   assign hpd_in  = DIFF_W'(restored) - DIFF_W'(low_rest);

   // Restored high-pass weighted by the highlight alpha, rounded half up.
   assign hpp   = HPP_W'(signed'({1'b0, alpha})) * HPP_W'(hpd_ff[A_ST]);
   assign hp_in = TERM_W'((hpp + HPP_W'(HALF)) >>> F);

   always_comb begin
      if (cfg.mono_mode) begin
         term = SUM_W'(mono_term);
      end else begin
         term = SUM_W'(ldiff_ff[HP_ST]) - SUM_W'(adj);
      end
      sum = SUM_W'(rest_ff[HP_ST]) + term - SUM_W'(hp_ff);
      if (cfg.mono_mode && !PRIMARY) begin
         result_in = '0;
      end else if (sum > SUM_W'(SAT_MAX)) begin
         result_in = DATA_W'(SAT_MAX);
      end else if (sum < SUM_W'(SAT_MIN)) begin
         result_in = DATA_W'(SAT_MIN);
      end else begin
         result_in = sum[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         rest_ff[0]  <= restored;
         ldiff_ff[0] <= blur_delta;
         hpd_ff[0]   <= hpd_in;
         prod_ff     <= prod_in;
      end
      if (stage_en[HP_ST]) begin
         hp_ff <= hp_in;
      end
      if (stage_en[OUT_ST]) begin
         result_ff <= result_in;
      end
   end

   for (genvar s = 1; s <= HP_ST; s++) begin : g_carry
      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            rest_ff[s]  <= rest_ff[s-1];
            ldiff_ff[s] <= ldiff_ff[s-1];
         end
      end
   end

   for (genvar s = 1; s <= A_ST; s++) begin : g_hpd
      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            hpd_ff[s] <= hpd_ff[s-1];
         end
      end
   end

   assign prod   = prod_ff;
   assign result = result_ff;

endmodule

// File: rtl/lftc_merge.sv
module lftc_merge #(
   parameter int FRACTION_BITS = 12
) (
   input  logic                                           clock,
   input  logic [FRACTION_BITS+5:0]                       stage_en,
   input  lftc_pkg::cfg_type                              cfg,
   input  logic signed [lftc_pkg::DATA_W-1:0]             reference_r,
   input  logic signed [lftc_pkg::DATA_W-1:0]             reference_g,
   input  logic signed [lftc_pkg::DATA_W-1:0]             reference_b,
   input  logic signed [lftc_pkg::DATA_W-1:0]             blur_delta_r,
   input  logic signed [lftc_pkg::DATA_W+FRACTION_BITS:0] prod_r,
   input  logic signed [lftc_pkg::DATA_W+FRACTION_BITS:0] prod_g,
   input  logic signed [lftc_pkg::DATA_W+FRACTION_BITS:0] prod_b,
   output logic signed [lftc_pkg::DIFF_W-1:0]             d,
   output logic signed [lftc_pkg::TERM_W-1:0]             adj,
   output logic signed [lftc_pkg::TERM_W-1:0]             mono_term
);
   import lftc_pkg::*;

   localparam int F      = FRACTION_BITS;
   localparam int HP_ST  = F + 4;
   localparam int ONE    = 1 << F;
   localparam int HALF   = 1 << (F - 1);
   localparam int HALF2  = 1 << (2 * F - 1);
   localparam int SW     = F + 1;
   localparam int PROD_W = DATA_W + F + 1;
   localparam int LUMD_W = PROD_W + 2;
   localparam int ADJP_W = LUMD_W + F + 2;
   localparam int MP_W   = DATA_W + F + 2;

   logic signed [DATA_W-1:0] max_rg;
   logic signed [DATA_W-1:0] max_rgb;
   logic signed [DATA_W-1:0] lum;
   logic signed [DIFF_W-1:0] d_ff;
   logic signed [DIFF_W-1:0] d_in;
   logic [SW-1:0]            ls;
   logic [SW-1:0]            lr;
   logic signed [MP_W-1:0]   mono_p;
   logic signed [TERM_W-1:0] mono_term_in;
   logic signed [TERM_W-1:0] mono_term_ff [0:HP_ST];
   logic signed [LUMD_W-1:0] lumd_ff;
   logic signed [LUMD_W-1:0] lumd_in;
   logic signed [ADJP_W-1:0] adjp_ff;
   logic signed [ADJP_W-1:0] adjp_in;
   logic signed [TERM_W-1:0] adj_in;
   logic signed [TERM_W-1:0] adj_ff [3:HP_ST];

   // In mono mode only the first channel carries the reference level.
   assign max_rg  = (reference_g > reference_r) ? reference_g : reference_r;
   assign max_rgb = (reference_b > max_rg) ? reference_b : max_rg;
   assign lum     = cfg.mono_mode ? reference_r : max_rgb;
   assign d_in    = DIFF_W'(lum) - DIFF_W'(signed'(cfg.hl_knee));

   always_comb begin
      if (32'(cfg.luma_gain) > ONE) begin
         ls = SW'(ONE);
      end else begin
         ls = SW'(cfg.luma_gain);
      end
      lr = SW'(ONE) - ls;
   end

   assign mono_p       = MP_W'(blur_delta_r) * MP_W'(signed'({1'b0, ls}));
   assign mono_term_in = TERM_W'((mono_p + MP_W'(HALF)) >>> F);

   // The luma of the difference is gathered from the three lanes.
   assign lumd_in = LUMD_W'(prod_r) + LUMD_W'(prod_g) + LUMD_W'(prod_b);
   assign adjp_in = ADJP_W'(lumd_ff) * ADJP_W'(signed'({1'b0, lr}));
   assign adj_in  = TERM_W'((adjp_ff + ADJP_W'(HALF2)) >>> (2 * F));

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         d_ff            <= d_in;
         mono_term_ff[0] <= mono_term_in;
      end
      if (stage_en[1]) begin
         lumd_ff <= lumd_in;
      end
      if (stage_en[2]) begin
         adjp_ff <= adjp_in;
      end
      if (stage_en[3]) begin
         adj_ff[3] <= adj_in;
      end
   end

   for (genvar s = 1; s <= HP_ST; s++) begin : g_mono
      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            mono_term_ff[s] <= mono_term_ff[s-1];
         end
      end
   end

   for (genvar s = 4; s <= HP_ST; s++) begin : g_adj
      always_ff @(posedge clock) begin
         if (stage_en[s]) begin
            adj_ff[s] <= adj_ff[s-1];
         end
      end
   end

   assign d         = d_ff;
   assign adj       = adj_ff[HP_ST];
   assign mono_term = mono_term_ff[HP_ST];

endmodule

// File: rtl/lftc_mask.sv
module lftc_mask #(
   parameter int FRACTION_BITS = 12
) (
   input  logic                               clock,
   input  logic [FRACTION_BITS+5:0]           stage_en,
   input  lftc_pkg::cfg_type                  cfg,
   input  logic signed [lftc_pkg::DIFF_W-1:0] d,
   output logic [FRACTION_BITS:0]             alpha
);
   import lftc_pkg::*;

   localparam int F    = FRACTION_BITS;
   localparam int T_ST = F + 1;
   localparam int M_ST = F + 2;
   localparam int A_ST = F + 3;
   localparam int ONE  = 1 << F;
   localparam int TW   = F + 1;
   localparam int SW   = F + 2;
   localparam int PW   = 2 * TW + 1;

   logic [TRANS_W-1:0] trans_eff;
   logic               zero_in;
   logic               one_in;
   logic [TRANS_W-1:0] rem0;
   logic [TRANS_W-1:0] rem_ff  [1:F];
   logic [F-1:0]       quo_ff  [1:F];
   logic               zero_ff [1:F];
   logic               one_ff  [1:F];
   logic [TW-1:0]      t_in;
   logic [2*TW-1:0]    t2p;
   logic [TW-1:0]      t_ff;
   logic [TW-1:0]      t2_ff;
   logic [SW-1:0]      slope;
   logic [PW-1:0]      mp;
   logic [TW-1:0]      mask_ff;
   logic [TW-1:0]      ds;
   logic [TW-1:0]      dr;
   logic [2*TW-1:0]    ap;
   logic [TW-1:0]      alpha_ff;
   logic [TW-1:0]      alpha_in;

   assign trans_eff = (cfg.hl_ramp == '0) ? TRANS_W'(1) : cfg.hl_ramp;
   assign zero_in   = d[DIFF_W-1] || (d == '0);
   assign one_in    = (d >= DIFF_W'(signed'({1'b0, trans_eff})));
   // Inside the ramp 0 < d < transition, so d fits the remainder width.
   assign rem0      = d[TRANS_W-1:0];

   // Restoring division d * ONE / transition, one quotient bit per stage.
   for (genvar k = 1; k <= F; k++) begin : g_div
      logic [TRANS_W-1:0] rem_prev;
      logic [F-1:0]       quo_prev;
      logic               zero_prev;
      logic               one_prev;
      logic [TRANS_W:0]   shifted;
      logic               take;

      if (k == 1) begin : g_first
         assign rem_prev  = rem0;
         assign quo_prev  = '0;
         assign zero_prev = zero_in;
         assign one_prev  = one_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign zero_prev = zero_ff[k-1];
         assign one_prev  = one_ff[k-1];
      end

      assign shifted = {rem_prev, 1'b0};
      assign take    = (shifted >= {1'b0, trans_eff});

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            rem_ff[k]  <= take ? TRANS_W'(shifted - {1'b0, trans_eff})
                               : shifted[TRANS_W-1:0];
            quo_ff[k]  <= {quo_prev[F-2:0], take};
            zero_ff[k] <= zero_prev;
            one_ff[k]  <= one_prev;
         end
      end
   end

   always_comb begin
      if (zero_ff[F]) begin
         t_in = '0;
      end else if (one_ff[F]) begin
         t_in = TW'(ONE);
      end else begin
         t_in = {1'b0, quo_ff[F]};
      end
   end

   assign t2p = (2 * TW)'(t_in) * (2 * TW)'(t_in);

   // Smoothstep: t^2 * (3 - 2t), which never exceeds one.
   assign slope = SW'(3 * ONE) - {t_ff, 1'b0};
   assign mp    = PW'(t2_ff) * PW'(slope);

   always_comb begin
      if (32'(cfg.detail_strength) > ONE) begin
         ds = TW'(ONE);
      end else begin
         ds = TW'(cfg.detail_strength);
      end
      dr       = TW'(ONE) - ds;
      ap       = (2 * TW)'(mask_ff) * (2 * TW)'(dr);
      alpha_in = cfg.highlight_enable ? ap[2*F:F] : '0;
   end

   always_ff @(posedge clock) begin
      if (stage_en[T_ST]) begin
         t_ff  <= t_in;
         t2_ff <= t2p[2*F:F];
      end
      if (stage_en[M_ST]) begin
         mask_ff <= mp[2*F:F];
      end
      if (stage_en[A_ST]) begin
         alpha_ff <= alpha_in;
      end
   end

   assign alpha = alpha_ff;

endmodule

// File: test/low_frequency_transfer_compose_core_tb.sv
`timescale 1ns / 1ps

module low_frequency_transfer_compose_core_tb;
   import lftc_pkg::*;

   localparam int FRAC         = 12;
   localparam int RANDOM_ITEMS = 1030;
   localparam int PHASE_LEN    = 80;
   localparam int QUIET_ITEMS  = 150;
   localparam int HOLD_AT      = 250;
   localparam int LONG_HOLD    = 100;

   // Indexes past the register list; writes to them must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef logic signed [DATA_W-1:0] sample_type;

   typedef struct packed {
      sample_type [2:0] restored;
      sample_type [2:0] reference;
      sample_type [2:0] blur_delta;
      sample_type [2:0] low_rest;
   } pixel_type;

   typedef struct packed {
      sample_type r;
      sample_type g;
      sample_type b;
   } composed_type;

   typedef struct packed {
      cfg_type      cf;
      pixel_type    px;
      bit           typed;
      composed_type want;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   sample_type            req_restored_r = '0;
   sample_type            req_restored_g = '0;
   sample_type            req_restored_b = '0;
   sample_type            req_reference_r = '0;
   sample_type            req_reference_g = '0;
   sample_type            req_reference_b = '0;
   sample_type            req_blur_delta_r = '0;
   sample_type            req_blur_delta_g = '0;
   sample_type            req_blur_delta_b = '0;
   sample_type            req_low_rest_r = '0;
   sample_type            req_low_rest_g = '0;
   sample_type            req_low_rest_b = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   sample_type            rsp_out_r;
   sample_type            rsp_out_g;
   sample_type            rsp_out_b;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   cfg_type            shadow_cfg;
   composed_type       pending_pixels[$];
   directed_row_type   directed_rows[$];
   int                 fail_count = 0;
   int                 cycle_count = 0;
   int                 stall_left = 0;
   logic               quiet = 1'b0;
   logic               hold_request = 1'b0;
   logic               hold_taken = 1'b0;
   logic               calm;

   low_frequency_transfer_compose_core #(
      .FRACTION_BITS(FRAC)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_restored_r(req_restored_r),
      .req_restored_g(req_restored_g),
      .req_restored_b(req_restored_b),
      .req_reference_r(req_reference_r),
      .req_reference_g(req_reference_g),
      .req_reference_b(req_reference_b),
      .req_blur_delta_r(req_blur_delta_r),
      .req_blur_delta_g(req_blur_delta_g),
      .req_blur_delta_b(req_blur_delta_b),
      .req_low_rest_r(req_low_rest_r),
      .req_low_rest_g(req_low_rest_g),
      .req_low_rest_b(req_low_rest_b),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_r(rsp_out_r),
      .rsp_out_g(rsp_out_g),
      .rsp_out_b(rsp_out_b),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // During the calm stretch of each period neither side inserts random stalls or pauses.
   assign calm = (cycle_count % 512) >= 384;

   function automatic longint round_shift(input longint x, input int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic sample_type clamp16(input longint v);
      if (v > SAT_MAX) return DATA_W'(SAT_MAX);
      if (v < SAT_MIN) return DATA_W'(SAT_MIN);
      return DATA_W'(v);
   endfunction

   function automatic composed_type compose_pixel(input cfg_type cf, input pixel_type p);
      longint one, ls, lr, ds, dr, alpha, lum, span, excess, t, t2, mask;
      longint kr, kg, kb, lumd, adj, hp;
      longint rest [3];
      longint refv [3];
      longint diff [3];
      longint lrst [3];
      longint res [3];
      composed_type y;
      one = longint'(1) << FRAC;
      for (int ch = 0; ch < 3; ch++) begin
         rest[ch] = longint'($signed(p.restored[ch]));
         refv[ch] = longint'($signed(p.reference[ch]));
         diff[ch] = longint'($signed(p.blur_delta[ch]));
         lrst[ch] = longint'($signed(p.low_rest[ch]));
      end
      ls = (cf.luma_gain > one) ? one : longint'(cf.luma_gain);
      lr = one - ls;
      ds = (cf.detail_strength > one) ? one : longint'(cf.detail_strength);
      dr = one - ds;
      alpha = 0;
      if (cf.highlight_enable) begin
         lum = refv[0];
         if (!cf.mono_mode) begin
            if (refv[1] > lum) lum = refv[1];
            if (refv[2] > lum) lum = refv[2];
         end
         span = (cf.hl_ramp == 0) ? 1 : longint'(cf.hl_ramp);
         excess = lum - longint'($signed(cf.hl_knee));
         if (excess <= 0) t = 0;
         else if (excess >= span) t = one;
         else t = (excess * one) / span;
         // Smoothstep: t^2 * (3 - 2t), each product floored back to the grid.
         t2 = (t * t) >>> FRAC;
         mask = (t2 * (3 * one - 2 * t)) >>> FRAC;
         alpha = (mask * dr) >>> FRAC;
      end
      if (cf.mono_mode) begin
         hp = round_shift(alpha * (rest[0] - lrst[0]), FRAC);
         y.r = clamp16(rest[0] + round_shift(diff[0] * ls, FRAC) - hp);
         y.g = '0;
         y.b = '0;
      end else begin
         kr = (2126 * one + 5000) / 10000;
         kg = (7152 * one + 5000) / 10000;
         kb = (722 * one + 5000) / 10000;
         lumd = kr * diff[0] + kg * diff[1] + kb * diff[2];
         adj = round_shift(lumd * lr, 2 * FRAC);
         for (int ch = 0; ch < 3; ch++) begin
            hp = round_shift(alpha * (rest[ch] - lrst[ch]), FRAC);
            res[ch] = rest[ch] + diff[ch] - adj - hp;
         end
         y.r = clamp16(res[0]);
         y.g = clamp16(res[1]);
         y.b = clamp16(res[2]);
      end
      return y;
   endfunction

   function automatic cfg_type make_cfg(input bit mono, input bit hl, input int ls,
                                        input int th, input int tr, input int ds);
      cfg_type c;
      c.mono_mode = mono;
      c.highlight_enable = hl;
      c.luma_gain = STR_W'(ls);
      c.hl_knee = DATA_W'(th);
      c.hl_ramp = TRANS_W'(tr);
      c.detail_strength = STR_W'(ds);
      return c;
   endfunction

   function automatic int pick_strength();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 4096;
         2: return int'($urandom_range(0, 8191));
         default: return int'($urandom_range(0, 4096));
      endcase
   endfunction

   function automatic cfg_type random_cfg();
      int th, tr;
      case ($urandom_range(0, 2))
         0: th = $urandom;
         default: th = int'($urandom_range(0, 8192));
      endcase
      case ($urandom_range(0, 4))
         0: tr = 0;
         1: tr = 32767;
         2: tr = int'($urandom_range(0, 32767));
         default: tr = int'($urandom_range(1, 2048));
      endcase
      return make_cfg($urandom_range(0, 2) == 0, $urandom_range(0, 3) != 0,
                      pick_strength(), th, tr, pick_strength());
   endfunction

   function automatic sample_type pick_sample(input bit shaped);
      if (shaped && $urandom_range(0, 1) == 1)
         return DATA_W'(int'($urandom_range(0, 16384)) - 8192);
      return DATA_W'($urandom);
   endfunction

   // A shaped pixel puts most reference values around the mask ramp so that
   // the partial-alpha path is exercised, not just the fully on and off ends.
   function automatic pixel_type random_pixel(input cfg_type cf, input bit shaped);
      pixel_type p;
      longint span;
      span = (cf.hl_ramp == 0) ? 1 : longint'(cf.hl_ramp);
      for (int ch = 0; ch < 3; ch++) begin
         p.restored[ch] = pick_sample(shaped);
         p.blur_delta[ch] = pick_sample(shaped);
         p.low_rest[ch] = pick_sample(shaped);
         if (shaped && $urandom_range(0, 3) != 0)
            p.reference[ch] = clamp16(longint'($signed(cf.hl_knee)) - span - 1
                                      + longint'($urandom_range(0, int'(3 * span + 2))));
         else
            p.reference[ch] = DATA_W'($urandom);
      end
      return p;
   endfunction

   function automatic pixel_type flat(input int rest, input int refv, input int diff,
                                      input int lrst);
      pixel_type p;
      for (int ch = 0; ch < 3; ch++) begin
         p.restored[ch] = DATA_W'(rest);
         p.reference[ch] = DATA_W'(refv);
         p.blur_delta[ch] = DATA_W'(diff);
         p.low_rest[ch] = DATA_W'(lrst);
      end
      return p;
   endfunction

   function automatic void add_row(input cfg_type cf, input pixel_type px, input bit typed,
                                   input int er, input int eg, input int eb);
      directed_row_type row;
      row.cf = cf;
      row.px = px;
      row.typed = typed;
      row.want.r = DATA_W'(er);
      row.want.g = DATA_W'(eg);
      row.want.b = DATA_W'(eb);
      directed_rows.push_back(row);
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
   endtask

   // Registers change only once the pipeline has drained.
   task automatic apply_cfg(input cfg_type nc);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      write_csr(CSR_MONO_MODE, CSR_DATA_W'(nc.mono_mode));
      write_csr(CSR_HIGHLIGHT_ENABLE, CSR_DATA_W'(nc.highlight_enable));
      write_csr(CSR_LUMA_GAIN, CSR_DATA_W'(nc.luma_gain));
      write_csr(CSR_HL_KNEE, CSR_DATA_W'(nc.hl_knee));
      write_csr(CSR_HL_RAMP, CSR_DATA_W'(nc.hl_ramp));
      write_csr(CSR_DETAIL_STRENGTH, CSR_DATA_W'(nc.detail_strength));
      write_csr(CSR_SPARE_LO, CSR_DATA_W'($urandom));
      write_csr(CSR_SPARE_HI, CSR_DATA_W'($urandom));
      csr_write_en <= 1'b0;
      shadow_cfg = nc;
   endtask

   task automatic pause(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic offer(input pixel_type p, input bit typed, input composed_type typed_out);
      req_valid <= 1'b1;
      req_restored_r <= p.restored[0];
      req_restored_g <= p.restored[1];
      req_restored_b <= p.restored[2];
      req_reference_r <= p.reference[0];
      req_reference_g <= p.reference[1];
      req_reference_b <= p.reference[2];
      req_blur_delta_r <= p.blur_delta[0];
      req_blur_delta_g <= p.blur_delta[1];
      req_blur_delta_b <= p.blur_delta[2];
      req_low_rest_r <= p.low_rest[0];
      req_low_rest_g <= p.low_rest[1];
      req_low_rest_b <= p.low_rest[2];
      do @(posedge clock); while (!req_ready);
      pending_pixels.push_back(typed ? typed_out : compose_pixel(shadow_cfg, p));
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
         hold_taken <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (hold_request && !hold_taken) begin
         // One long back-pressure stretch, so the pipeline fills and stalls req.
         hold_taken <= 1'b1;
         rsp_ready <= 1'b0;
         stall_left <= LONG_HOLD - 1;
      end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      composed_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected item at %0t: got %0d %0d %0d", $realtime,
                        rsp_out_r, rsp_out_g, rsp_out_b);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_out_r !== want.r || rsp_out_g !== want.g || rsp_out_b !== want.b) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch at %0t: expected %0d %0d %0d, got %0d %0d %0d",
                           $realtime, want.r, want.g, want.b,
                           rsp_out_r, rsp_out_g, rsp_out_b);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      cfg_type rst_cfg, hl_cfg, ramp_cfg;
      rst_cfg = make_cfg(1'b0, 1'b0, 4096, 3277, 410, 0);
      hl_cfg = make_cfg(1'b0, 1'b1, 4096, 0, 0, 0);
      ramp_cfg = make_cfg(1'b0, 1'b1, 2048, -32768, 32767, 2048);
      shadow_cfg = rst_cfg;

      // Register defaults after reset: full luma strength leaves the difference as is.
      add_row(rst_cfg, flat(0, 0, 0, 0), 1'b1, 0, 0, 0);
      add_row(rst_cfg, flat(32767, 0, 32767, 0), 1'b1, 32767, 32767, 32767);
      add_row(rst_cfg, flat(-32768, 0, -32768, 0), 1'b1, -32768, -32768, -32768);
      add_row(rst_cfg, flat(1000, 0, -200, 0), 1'b1, 800, 800, 800);
      add_row(rst_cfg, random_pixel(rst_cfg, 1'b1), 1'b0, 0, 0, 0);
      // Zero luma strength removes the whole luma of a gray difference.
      add_row(make_cfg(1'b0, 1'b0, 0, 3277, 410, 0), flat(1234, 0, 500, 0), 1'b1,
              1234, 1234, 1234);
      add_row(make_cfg(1'b0, 1'b0, 0, 3277, 410, 0), random_pixel(rst_cfg, 1'b0), 1'b0,
              0, 0, 0);
      // A strength above one acts as one.
      add_row(make_cfg(1'b0, 1'b0, 8191, 3277, 410, 0), flat(10, 0, 20, 0), 1'b1, 30, 30, 30);
      add_row(make_cfg(1'b0, 1'b0, 2048, 3277, 410, 0), random_pixel(rst_cfg, 1'b0), 1'b0,
              0, 0, 0);
      // Mono mode reads lane zero only and zeroes the other two outputs.
      add_row(make_cfg(1'b1, 1'b0, 4096, 3277, 410, 0), flat(100, 7777, 200, -5), 1'b1,
              300, 0, 0);
      add_row(make_cfg(1'b1, 1'b0, 4096, 3277, 410, 0), flat(32767, 0, 32767, 0), 1'b1,
              32767, 0, 0);
      add_row(make_cfg(1'b1, 1'b0, 0, 3277, 410, 0), flat(-4000, 0, 3000, 0), 1'b1,
              -4000, 0, 0);
      add_row(make_cfg(1'b1, 1'b0, 8191, 3277, 410, 0), random_pixel(rst_cfg, 1'b0), 1'b0,
              0, 0, 0);
      add_row(make_cfg(1'b1, 1'b0, 2048, 3277, 410, 0), random_pixel(rst_cfg, 1'b1), 1'b0,
              0, 0, 0);
      // A zero transition counts as one step, so any reference above threshold is full alpha.
      add_row(hl_cfg, flat(5000, 1, 100, 3000), 1'b1, 3100, 3100, 3100);
      add_row(hl_cfg, flat(5000, 0, 100, 3000), 1'b1, 5100, 5100, 5100);
      add_row(make_cfg(1'b0, 1'b1, 4096, 0, 0, 8191), flat(5000, 1, 100, 3000), 1'b1,
              5100, 5100, 5100);
      add_row(make_cfg(1'b1, 1'b1, 4096, 0, 0, 0), flat(5000, 1, 100, 3000), 1'b1,
              3100, 0, 0);
      add_row(make_cfg(1'b1, 1'b1, 4096, 0, 0, 0), random_pixel(hl_cfg, 1'b1), 1'b0, 0, 0, 0);
      add_row(ramp_cfg, random_pixel(ramp_cfg, 1'b1), 1'b0, 0, 0, 0);
      add_row(ramp_cfg, random_pixel(ramp_cfg, 1'b0), 1'b0, 0, 0, 0);
      add_row(make_cfg(1'b0, 1'b1, 0, 32767, 32767, 0), flat(32767, 32767, -32768, -32768),
              1'b0, 0, 0, 0);
      add_row(make_cfg(1'b0, 1'b1, 4096, 0, 1, 4096), random_pixel(hl_cfg, 1'b1), 1'b0,
              0, 0, 0);
      add_row(make_cfg(1'b0, 1'b1, 4096, 4096, 2048, 0), flat(-7000, 5120, 300, 9000), 1'b0,
              0, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].cf != shadow_cfg) apply_cfg(directed_rows[k].cf);
         offer(directed_rows[k].px, directed_rows[k].typed, directed_rows[k].want);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_LEN == 0) apply_cfg(random_cfg());
         if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet <= 1'b1;
         if (i == HOLD_AT) hold_request <= 1'b1;
         if (!quiet && !calm && $urandom_range(0, 4) == 0) pause($urandom_range(1, 6));
         offer(random_pixel(shadow_cfg, $urandom_range(0, 3) != 0), 1'b0, '0);
      end

      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (FRAC + 12) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
